>>> hw/rtl/aphd_pkg.sv
// ----------------------------------------------------------------------------
// aphd_pkg
// shared types, sizes and codes of the analog pixel hit decoder
// ----------------------------------------------------------------------------
package aphd_pkg;

  // sizing
  localparam int MAX_CHIPS    = 8;
  localparam int EVENT_DEPTH  = 256;
  localparam int MARKER_SLOTS = 16;
  localparam int LEVELS       = 5;

  localparam int SMP_W       = 12;
  localparam int CHIP_W      = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam int CHIPS_CNT_W = $clog2(MAX_CHIPS + 1);
  localparam int ADDR_W      = $clog2(EVENT_DEPTH);
  localparam int CNT_W       = $clog2(EVENT_DEPTH + 2);
  localparam int MK_IDX_W    = $clog2(MARKER_SLOTS);
  localparam int MK_CNT_W    = $clog2(MARKER_SLOTS + 2);
  localparam int BASE_W      = ADDR_W + 2;
  localparam int DIGIT_W     = 3;
  localparam int TC_W        = 6;
  localparam int TR_W        = 8;

  // event framing
  localparam int HEADER_MARKERS = 5;  // markers that are not chip headers
  localparam int FIRST_MARKER   = 3;  // marker slot of the first chip
  localparam int BASE_OFS       = 2;  // hit base offset from the chip marker
  localparam int HIT_STRIDE     = 6;  // samples per hit
  localparam int HIT_SPAN       = 7;  // base + span must not pass next marker
  localparam int ADDR_DIGITS    = 5;  // column and row digits per hit
  localparam int COL_DIGITS     = 2;
  localparam int ROW_TOP        = 80;

  // mode codes
  localparam logic MODE_LEVEL  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_NOCHIP  = 3'd2;
  localparam logic [2:0] ST_MANY    = 3'd3;
  localparam logic [2:0] ST_OVERFL  = 3'd4;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef smp_t [LEVELS-1:0] level_row_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic              mode;
    logic [2:0]        chip_index;
    logic [2:0]        level_index;
    logic signed [11:0] threshold_value;
    logic signed [11:0] sample;
    logic              last_sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         hit_chip;
    logic [6:0]         column;
    logic signed [7:0]  row;
    logic signed [11:0] pulse_height;
    logic               end_of_event;
  } out_item_t;

endpackage

>>> hw/rtl/aphd_quant.sv
// ----------------------------------------------------------------------------
// aphd_quant
// level quantizer: first of the ascending thresholds that the sample does
// not exceed, or the level count when there is none
// ----------------------------------------------------------------------------
module aphd_quant import aphd_pkg::*; (
  input  smp_t       sample_i,
  input  level_row_t levels_i,
  output digit_t     digit_o
);

  always_comb begin
    digit_o = DIGIT_W'(LEVELS);
    // lowest matching level wins
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if ($signed(sample_i) <= $signed(levels_i[k])) begin
        digit_o = DIGIT_W'(k);
      end
    end
  end

endmodule

>>> hw/rtl/analog_pixel_hit_decoder.sv
// ----------------------------------------------------------------------------
// analog_pixel_hit_decoder
// collects one event of analog readout samples, finds ultrablack markers and
// decodes pixel hits (column, row, pulse height) chip by chip
// ----------------------------------------------------------------------------
// sequence: thresholds and event samples are taken while idle; after the
//   last sample the decoder checks the event, starts the first chip, reads
//   and quantizes each hit's samples, steps chip by chip and closes the event
// throughput: one shared quantizer; each sample store read is registered and
//   quantized before the next read, and a hit waits while the output is full
// reset: register -500, level table zero, counts zero; sample and marker
//   stores hold no reset value and are only read where this event wrote them
// ----------------------------------------------------------------------------
module analog_pixel_hit_decoder import aphd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel (ultrablack threshold)
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  smp_t        cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  // one-hot sequencer
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,  // taking thresholds and samples
    S_CHECK = 9'b000000010,  // classify the finished event
    S_HERE  = 9'b000000100,  // first chip marker arrives
    S_NEXT  = 9'b000001000,  // following marker arrives
    S_TEST  = 9'b000010000,  // room for another hit before the next marker?
    S_RD    = 9'b000100000,  // issue a sample store read
    S_QNT   = 9'b001000000,  // quantize the sample just read
    S_EMIT  = 9'b010000000,  // hand the hit to the output register
    S_CLOSE = 9'b100000000   // closing result, counts back to zero
  } state_t;

  state_t state_r, state_nxt;

  // configuration register, always ready
  smp_t ub_thr_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ub_thr_r <= smp_t'(-500);
    end else if (cfg_valid) begin
      ub_thr_r <= cfg_data;
    end
  end

  // input transfer
  logic in_xfer, smp_xfer, lvl_xfer;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign smp_xfer = in_xfer && (in_data.mode == MODE_SAMPLE);
  assign lvl_xfer = in_xfer && (in_data.mode == MODE_LEVEL);

  // level table: one row of five thresholds per chip, cleared by reset
  level_row_t level_table_r [MAX_CHIPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < MAX_CHIPS; c++) begin
        level_table_r[c] <= '0;
      end
    end else if (lvl_xfer && (int'(in_data.chip_index) < MAX_CHIPS) &&
                 (int'(in_data.level_index) < LEVELS)) begin
      level_table_r[CHIP_W'(in_data.chip_index)][in_data.level_index] <=
        in_data.threshold_value;
    end
  end

  // event counters; the sample count parks one past the depth on overflow
  logic [CNT_W-1:0]    smp_cnt_r, smp_cnt_nxt;
  logic [MK_CNT_W-1:0] mk_cnt_r, mk_cnt_nxt;
  logic                store_room, is_marker, clr_counts;

  assign store_room = (smp_cnt_r < CNT_W'(EVENT_DEPTH));
  assign is_marker  = ($signed(in_data.sample) < $signed(ub_thr_r));

  always_comb begin
    smp_cnt_nxt = smp_cnt_r;
    mk_cnt_nxt  = mk_cnt_r;
    if (clr_counts) begin
      smp_cnt_nxt = '0;
      mk_cnt_nxt  = '0;
    end else if (smp_xfer) begin
      if (store_room) begin
        smp_cnt_nxt = smp_cnt_r + CNT_W'(1);
        if (is_marker && (mk_cnt_r <= MK_CNT_W'(MARKER_SLOTS))) begin
          mk_cnt_nxt = mk_cnt_r + MK_CNT_W'(1);
        end
      end else begin
        smp_cnt_nxt = CNT_W'(EVENT_DEPTH + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_cnt_r <= '0;
      mk_cnt_r  <= '0;
    end else begin
      smp_cnt_r <= smp_cnt_nxt;
      mk_cnt_r  <= mk_cnt_nxt;
    end
  end

  // sample store, one write port while loading, one registered read port
  smp_t              sample_mem [EVENT_DEPTH];
  smp_t              smp_q_r;
  logic [ADDR_W-1:0] smp_raddr;

  always_ff @(posedge clk) begin
    if (smp_xfer && store_room) begin
      sample_mem[ADDR_W'(smp_cnt_r)] <= in_data.sample;
    end
    smp_q_r <= sample_mem[smp_raddr];
  end

  // marker position store, same arrangement
  logic [ADDR_W-1:0]   marker_mem [MARKER_SLOTS];
  logic [ADDR_W-1:0]   mk_q_r;
  logic [MK_IDX_W-1:0] mk_raddr;

  always_ff @(posedge clk) begin
    if (smp_xfer && store_room && is_marker &&
        (mk_cnt_r < MK_CNT_W'(MARKER_SLOTS))) begin
      marker_mem[MK_IDX_W'(mk_cnt_r)] <= ADDR_W'(smp_cnt_r);
    end
    mk_q_r <= marker_mem[mk_raddr];
  end

  // decode datapath registers
  logic [CHIP_W-1:0]      chip_r, chip_nxt;
  logic [CHIPS_CNT_W-1:0] chips;
  logic                   last_chip;
  logic [ADDR_W-1:0]      here_r, here_nxt, next_r, next_nxt;
  logic [BASE_W-1:0]      base_r, base_nxt;
  logic [2:0]             dig_r, dig_nxt;
  logic [TC_W-1:0]        tc_r, tc_nxt;
  logic [TR_W-1:0]        tr_r, tr_nxt;
  smp_t                   ph_r, ph_nxt;
  logic [2:0]             close_st_r, close_st_nxt;
  logic                   room_for_hit;
  digit_t                 digit;

  // chip count is only used once the event has passed the check
  assign chips     = CHIPS_CNT_W'(mk_cnt_r - MK_CNT_W'(HEADER_MARKERS));
  assign last_chip = ((CHIPS_CNT_W'(chip_r) + CHIPS_CNT_W'(1)) == chips);
  assign room_for_hit = ((base_r + BASE_W'(HIT_SPAN)) <= BASE_W'(next_r));

  // shared quantizer against the current chip's thresholds
  aphd_quant u_quant (
    .sample_i (smp_q_r),
    .levels_i (level_table_r[chip_r]),
    .digit_o  (digit)
  );

  // output register with its own valid, so a waiting result does not hold
  // the sequencer unless a new one is due
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    chip_nxt      = chip_r;
    here_nxt      = here_r;
    next_nxt      = next_r;
    base_nxt      = base_r;
    dig_nxt       = dig_r;
    tc_nxt        = tc_r;
    tr_nxt        = tr_r;
    ph_nxt        = ph_r;
    close_st_nxt  = close_st_r;
    clr_counts    = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mk_raddr      = MK_IDX_W'(FIRST_MARKER + 1) + MK_IDX_W'(chip_r);
    smp_raddr     = ADDR_W'(base_r + BASE_W'(1) + BASE_W'(dig_r));

    unique case (state_r)
      S_IDLE: begin
        if (smp_xfer && in_data.last_sample) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        mk_raddr = MK_IDX_W'(FIRST_MARKER);
        chip_nxt = '0;
        if (smp_cnt_r > CNT_W'(EVENT_DEPTH)) begin
          close_st_nxt = ST_OVERFL;
          state_nxt    = S_CLOSE;
        end else if (mk_cnt_r <= MK_CNT_W'(HEADER_MARKERS)) begin
          close_st_nxt = ST_NOCHIP;
          state_nxt    = S_CLOSE;
        end else if ((mk_cnt_r > MK_CNT_W'(HEADER_MARKERS + MAX_CHIPS)) ||
                     (mk_cnt_r > MK_CNT_W'(MARKER_SLOTS))) begin
          close_st_nxt = ST_MANY;
          state_nxt    = S_CLOSE;
        end else begin
          state_nxt = S_HERE;
        end
      end
      S_HERE: begin
        here_nxt  = mk_q_r;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        next_nxt  = mk_q_r;
        base_nxt  = BASE_W'(here_r) + BASE_W'(BASE_OFS);
        state_nxt = S_TEST;
      end
      S_TEST: begin
        dig_nxt = '0;
        tc_nxt  = '0;
        tr_nxt  = '0;
        if (room_for_hit) begin
          state_nxt = S_RD;
        end else if (last_chip) begin
          close_st_nxt = ST_DONE;
          state_nxt    = S_CLOSE;
        end else begin
          // next chip starts at this chip's closing marker
          chip_nxt  = chip_r + CHIP_W'(1);
          here_nxt  = next_r;
          mk_raddr  = MK_IDX_W'(FIRST_MARKER + 1) + MK_IDX_W'(chip_r) +
                      MK_IDX_W'(1);
          state_nxt = S_NEXT;
        end
      end
      S_RD: begin
        state_nxt = S_QNT;
      end
      S_QNT: begin
        // base-six digits, most significant first
        if (dig_r < 3'(COL_DIGITS)) begin
          tc_nxt = TC_W'({2'b00, tc_r, 2'b00} + {3'b000, tc_r, 1'b0} +
                         (TC_W + 2)'(digit));
        end else if (dig_r < 3'(ADDR_DIGITS)) begin
          tr_nxt = TR_W'({2'b00, tr_r, 2'b00} + {3'b000, tr_r, 1'b0} +
                         (TR_W + 2)'(digit));
        end else begin
          ph_nxt = smp_q_r;
        end
        dig_nxt = dig_r + 3'd1;
        if (dig_r == 3'(ADDR_DIGITS)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = ST_HIT;
          out_nxt.hit_chip     = 3'(chip_r);
          // odd row code selects the right-hand column of the pair
          out_nxt.column       = {tc_r, tr_r[0]};
          out_nxt.row          = 8'(ROW_TOP) - 8'(tr_r >> 1);
          out_nxt.pulse_height = ph_r;
          out_nxt.end_of_event = 1'b0;
          base_nxt             = base_r + BASE_W'(HIT_STRIDE);
          state_nxt            = S_TEST;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = close_st_r;
          out_nxt.hit_chip     = '0;
          out_nxt.column       = '0;
          out_nxt.row          = '0;
          out_nxt.pulse_height = '0;
          out_nxt.end_of_event = 1'b1;
          clr_counts           = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    chip_r     <= chip_nxt;
    here_r     <= here_nxt;
    next_r     <= next_nxt;
    base_r     <= base_nxt;
    dig_r      <= dig_nxt;
    tc_r       <= tc_nxt;
    tr_r       <= tr_nxt;
    ph_r       <= ph_nxt;
    close_st_r <= close_st_nxt;
    out_r      <= out_nxt;
  end

endmodule

>>> hw/rtl/aphd_checker.sv
// ----------------------------------------------------------------------------
// aphd_checker
// port-level checks of the analog pixel hit decoder
// ----------------------------------------------------------------------------
module aphd_checker import aphd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the closing result is the only one that ends the event
  a_eoe_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.end_of_event == (out_data.status != ST_HIT)))
    else $error("end of event does not match status");

  // decoding starts after the last sample transfer
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == MODE_SAMPLE) && in_data.last_sample
    |=> !in_ready)
    else $error("input taken while decoding");

  // a threshold write leaves the block ready
  a_level_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == MODE_LEVEL) |=> in_ready)
    else $error("threshold write stalled the input");

  // decoded columns stay inside the pixel array
  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.column <= 7'd71))
    else $error("column out of range");

endmodule

bind analog_pixel_hit_decoder aphd_checker u_aphd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the analog pixel hit decoder: a short table of
// directed transfers, then phases of randomised events under several
// ultrablack settings, each result compared with a behavioural decoder
// ----------------------------------------------------------------------------
module tb_top;
  import aphd_pkg::*;

  localparam int   CYCLE_LIMIT = 200000;  // far above the slowest legal run
  localparam int   HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int   SETTLE      = 16;      // quiet cycles before a register write
  localparam int   PHASE_ITEMS = 64;      // random transfers per phase
  localparam int   DIR_ROWS    = 23;
  localparam smp_t SMP_MIN     = -12'sd2048;

  // one row of the directed table
  typedef struct {
    in_item_t   item;
    bit         typed;     // closing status given here, not by the decoder model
    logic [2:0] close_st;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  smp_t      cfg_data  = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // behavioural copy of the decoder state
  smp_t      lvl_tab [MAX_CHIPS][LEVELS];
  smp_t      evt_buf [EVENT_DEPTH];
  int        mk_pos  [MARKER_SLOTS];
  int        smp_cnt;
  int        mk_cnt;
  smp_t      ub_thr;

  out_item_t fresh[$];         // results of the transfer just accepted
  out_item_t results_due[$];   // results still to come out of the block
  smp_t      ev_q[$];          // samples of the event being sent
  dir_row_t  dir_tab [DIR_ROWS];

  int        bad_cnt     = 0;
  int        phase_items = 0;
  int        cyc_cnt     = 0;
  bit        gaps_on     = 1'b1;
  bit        quiet       = 1'b0;
  bit        hold_req    = 1'b0;

  analog_pixel_hit_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  // first level whose threshold is not below the sample, five if none
  function automatic int quant(smp_t v, int chip);
    for (int k = 0; k < LEVELS; k++)
      if (v <= lvl_tab[chip][k]) return k;
    return LEVELS;
  endfunction

  function automatic out_item_t closing_result(logic [2:0] st);
    out_item_t r;
    r              = '0;
    r.status       = st;
    r.end_of_event = 1'b1;
    return r;
  endfunction

  // walk the stored event chip by chip once the last sample is in
  task automatic decode_event();
    int        chips, here, nxt, nh, b, tc, tr, col, row;
    out_item_t r;
    if (smp_cnt > EVENT_DEPTH) begin
      fresh.push_back(closing_result(ST_OVERFL));
      return;
    end
    chips = mk_cnt - HEADER_MARKERS;
    if (chips <= 0) begin
      fresh.push_back(closing_result(ST_NOCHIP));
      return;
    end
    if (chips > MAX_CHIPS || mk_cnt > MARKER_SLOTS) begin
      fresh.push_back(closing_result(ST_MANY));
      return;
    end
    for (int c = 0; c < chips; c++) begin
      here = mk_pos[FIRST_MARKER + c];
      nxt  = mk_pos[FIRST_MARKER + 1 + c];
      nh   = (nxt - here - 3) / HIT_STRIDE;   // truncates toward zero
      for (int h = 0; h < nh; h++) begin
        b  = here + BASE_OFS + HIT_STRIDE * h;
        tc = quant(evt_buf[b+1], c) * 6 + quant(evt_buf[b+2], c);
        tr = quant(evt_buf[b+3], c) * 36 + quant(evt_buf[b+4], c) * 6 +
             quant(evt_buf[b+5], c);
        if (tr % 2 == 0) begin
          row = 79 - (tr - 2) / 2;
          col = 2 * tc;
        end else begin
          row = 79 - (tr - 3) / 2;
          col = 2 * tc + 1;
        end
        r              = '0;
        r.status       = ST_HIT;
        r.hit_chip     = 3'(c);
        r.column       = 7'(col);
        r.row          = 8'(row);
        r.pulse_height = evt_buf[b+6];
        fresh.push_back(r);
      end
    end
    fresh.push_back(closing_result(ST_DONE));
  endtask

  // state update for one accepted input transfer
  task automatic absorb_item(input in_item_t it);
    smp_t v;
    fresh.delete();
    if (it.mode == MODE_LEVEL) begin
      // level indices past the fifth are dropped
      if (int'(it.chip_index) < MAX_CHIPS && int'(it.level_index) < LEVELS)
        lvl_tab[it.chip_index][it.level_index] = it.threshold_value;
      return;
    end
    if (smp_cnt < EVENT_DEPTH) begin
      v                = it.sample;
      evt_buf[smp_cnt] = v;
      if (v < ub_thr) begin
        if (mk_cnt < MARKER_SLOTS) mk_pos[mk_cnt] = smp_cnt & 255;
        if (mk_cnt <= MARKER_SLOTS) mk_cnt++;
      end
      smp_cnt++;
    end else begin
      smp_cnt = EVENT_DEPTH + 1;   // overflow sticks until the event closes
    end
    if (it.last_sample) begin
      decode_event();
      smp_cnt = 0;
      mk_cnt  = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // item builders; unused fields carry random junk
  // ---------------------------------------------------------------------------

  function automatic in_item_t mk_smp(smp_t s, bit last);
    in_item_t it;
    it             = in_item_t'($urandom);
    it.mode        = MODE_SAMPLE;
    it.sample      = s;
    it.last_sample = last;
    return it;
  endfunction

  function automatic in_item_t mk_lvl(int chip, int lvl, int val);
    in_item_t it;
    it                 = in_item_t'($urandom);
    it.mode            = MODE_LEVEL;
    it.chip_index      = 3'(chip);
    it.level_index     = 3'(lvl);
    it.threshold_value = smp_t'(val);
    return it;
  endfunction

  function automatic dir_row_t d_smp(int s, bit last, bit typed = 1'b0,
                                     logic [2:0] st = ST_DONE);
    dir_row_t d;
    d.item     = mk_smp(smp_t'(s), last);
    d.typed    = typed;
    d.close_st = st;
    return d;
  endfunction

  function automatic dir_row_t d_lvl(int chip, int lvl, int val);
    dir_row_t d;
    d.item     = mk_lvl(chip, lvl, val);
    d.typed    = 1'b0;
    d.close_st = ST_DONE;
    return d;
  endfunction

  // sample at or above the ultrablack threshold
  function automatic smp_t filler();
    int t;
    t = ub_thr;
    case ($urandom_range(7, 0))
      0:       return smp_t'(t);
      1:       return smp_t'(2047);
      default: return smp_t'(t + int'($urandom_range(2047 - t, 0)));
    endcase
  endfunction

  // sample strictly below the threshold; only called when one exists
  function automatic smp_t marker();
    int t;
    t = ub_thr;
    case ($urandom_range(7, 0))
      0:       return SMP_MIN;
      1:       return smp_t'(t - 1);
      default: return smp_t'(t - 1 - int'($urandom_range(t + 2047, 0)));
    endcase
  endfunction

  // address digit aimed at a level boundary of the chip
  function automatic smp_t digit(int chip);
    int k, v;
    k = $urandom_range(LEVELS, 0);
    if (k < LEVELS) v = lvl_tab[chip][k] - int'($urandom_range(1, 0));
    else            v = lvl_tab[chip][LEVELS-1] + 1;
    if ($urandom_range(7, 0) == 0) v = filler();
    if (v > 2047) v = 2047;
    if (v < int'(ub_thr)) v = ub_thr;   // must never read as a marker
    return smp_t'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input transfer; entered and left at a falling edge, valid left high
  task automatic push_item(input in_item_t it, input bit typed = 1'b0,
                           input logic [2:0] close_st = ST_DONE);
    if (gaps_on && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    absorb_item(it);
    if (typed) begin
      fresh.delete();
      fresh.push_back(closing_result(close_st));
    end
    foreach (fresh[i]) results_due.push_back(fresh[i]);
    phase_items++;
    @(negedge clk);
  endtask

  task automatic send_samples();
    foreach (ev_q[i]) push_item(mk_smp(ev_q[i], i == ev_q.size() - 1));
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cfg(input smp_t v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    ub_thr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // five ascending thresholds for one chip
  task automatic load_levels(input int chip);
    int v;
    v = -1200 + int'($urandom_range(900, 0));
    for (int k = 0; k < LEVELS; k++) begin
      push_item(mk_lvl(chip, k, (v > 2047) ? 2047 : v));
      v += 50 + int'($urandom_range(400, 0));
    end
  endtask

  // well-formed event: header markers, one marker per chip with its hits,
  // a marker closing the last chip and usually a trailing one
  task automatic build_event(input int nch);
    int nh, maxh;
    ev_q.delete();
    repeat ($urandom_range(2, 0)) ev_q.push_back(filler());
    repeat (FIRST_MARKER) begin
      ev_q.push_back(marker());
      if ($urandom_range(1, 0)) ev_q.push_back(filler());
    end
    maxh = (nch <= 3) ? 4 : 1;
    for (int c = 0; c < nch; c++) begin
      ev_q.push_back(marker());
      nh = $urandom_range(maxh, 0);
      if (nh == 0 && $urandom_range(3, 0) == 0) begin
        // markers closer than a hit span: hit count truncates to zero
        repeat ($urandom_range(2, 0)) ev_q.push_back(filler());
      end else begin
        repeat (BASE_OFS) ev_q.push_back(filler());
        repeat (nh) begin
          repeat (ADDR_DIGITS) ev_q.push_back(digit(c % MAX_CHIPS));
          ev_q.push_back(filler());   // pulse height
        end
        repeat ($urandom_range(HIT_STRIDE - 1, 0)) ev_q.push_back(filler());
      end
    end
    ev_q.push_back(marker());
    if ($urandom_range(9, 0) != 0) begin
      repeat ($urandom_range(2, 0)) ev_q.push_back(filler());
      ev_q.push_back(marker());
    end
    repeat ($urandom_range(1, 0)) ev_q.push_back(filler());
  endtask

  // randomised traffic of one phase
  task automatic run_phase(input int budget);
    int kind, nch, nmk;
    phase_items = 0;
    while (phase_items < budget) begin
      gaps_on = quiet ? 1'b0 : ($urandom_range(3, 0) != 0);
      kind    = $urandom_range(9, 0);
      if (kind <= 5 && ub_thr != SMP_MIN) begin
        case ($urandom_range(7, 0))
          0:       nch = MAX_CHIPS + int'($urandom_range(3, 1));
          1, 2:    nch = $urandom_range(MAX_CHIPS, 1);
          default: nch = $urandom_range(3, 1);
        endcase
        build_event(nch);
        send_samples();
      end else if (kind == 6 && ub_thr != SMP_MIN) begin
        // marker flood: too many chips, or more markers than slots
        nmk = $urandom_range(MARKER_SLOTS + 4, MAX_CHIPS + HEADER_MARKERS + 1);
        ev_q.delete();
        repeat (nmk) begin
          ev_q.push_back(marker());
          if ($urandom_range(2, 0) == 0) ev_q.push_back(filler());
        end
        send_samples();
      end else if (kind == 8) begin
        // stray threshold writes, out-of-range levels among them
        repeat ($urandom_range(4, 1))
          push_item(mk_lvl($urandom_range(7, 0), $urandom_range(7, 0), $urandom));
      end else if (kind == 9) begin
        load_levels($urandom_range(MAX_CHIPS - 1, 0));
      end else begin
        // broken event of raw samples
        ev_q.delete();
        repeat ($urandom_range(24, 1)) ev_q.push_back(smp_t'($urandom));
        send_samples();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(4, 0) == 0) begin
        stall_left = $urandom_range(2, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_cnt++;
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result with nothing outstanding: status %0d", out_data.status);
        bad_cnt++;
      end else begin
        want = results_due.pop_front();
        check_field("status",       want.status,       out_data.status);
        check_field("hit_chip",     want.hit_chip,     out_data.hit_chip);
        check_field("column",       want.column,       out_data.column);
        check_field("row",          want.row,          out_data.row);
        check_field("pulse_height", want.pulse_height, out_data.pulse_height);
        check_field("end_of_event", want.end_of_event, out_data.end_of_event);
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cyc_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    smp_t thr_plan [5];

    // model state after reset
    ub_thr  = -12'sd500;
    smp_cnt = 0;
    mk_cnt  = 0;
    foreach (lvl_tab[c, k]) lvl_tab[c][k] = '0;
    foreach (evt_buf[i]) evt_buf[i] = '0;
    foreach (mk_pos[i]) mk_pos[i] = 0;

    dir_tab = '{
      // lone ordinary sample straight after reset: no chips
      d_smp(0, 1'b1, 1'b1, ST_NOCHIP),
      // chip 0 levels, both extremes of the threshold range
      d_lvl(0, 0, -2048),
      d_lvl(0, 1, -100),
      d_lvl(0, 2, 100),
      d_lvl(0, 3, 300),
      d_lvl(0, 4, 2047),
      // level indices past the fifth are ignored
      d_lvl(0, 5, 0),
      d_lvl(7, 7, -1),
      // one chip, one hit: three header markers, chip marker at 3
      d_smp(-2048, 1'b0),
      d_smp(-501, 1'b0),
      d_smp(-1000, 1'b0),
      d_smp(-600, 1'b0),
      d_smp(0, 1'b0),
      d_smp(2047, 1'b0),
      // digits, the first sits exactly on the ultrablack boundary
      d_smp(-500, 1'b0),
      d_smp(2047, 1'b0),
      d_smp(-100, 1'b0),
      d_smp(300, 1'b0),
      d_smp(301, 1'b0),
      d_smp(2047, 1'b0),     // pulse height at its top
      d_smp(-700, 1'b0),     // closes chip 0
      d_smp(-2048, 1'b1),    // trailing marker ends the event
      // single marker event: no chips
      d_smp(-2048, 1'b1, 1'b1, ST_NOCHIP)
    };

    thr_plan[0] = -12'sd500;
    thr_plan[1] = 12'sd2047;
    thr_plan[2] = SMP_MIN;
    thr_plan[3] = smp_t'(-1500 + int'($urandom_range(1400, 0)));
    thr_plan[4] = smp_t'(-1500 + int'($urandom_range(1400, 0)));

    // synchronous reset
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i])
      push_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].close_st);

    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_cfg(thr_plan[p]);
      quiet   = (p == 4);   // no idling in the closing phase
      gaps_on = !quiet;
      if (p == 0) begin
        for (int c = 0; c < MAX_CHIPS; c++) load_levels(c);
        // receiver holds off while events keep coming, so the block backs up
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS);
        // event filling the store exactly
        build_event($urandom_range(3, 1));
        while (ev_q.size() < EVENT_DEPTH) ev_q.push_front(filler());
        send_samples();
        // event running past the store: overflow
        build_event($urandom_range(3, 1));
        while (ev_q.size() < EVENT_DEPTH + 2) ev_q.push_back(filler());
        send_samples();
      end else begin
        run_phase(PHASE_ITEMS);
      end
    end

    drain_results();
    repeat (32) @(negedge clk);
    if (bad_cnt == 0 && results_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/aphd_pkg.sv
hw/rtl/aphd_quant.sv
hw/rtl/analog_pixel_hit_decoder.sv
hw/rtl/aphd_checker.sv
sim/tb_top.sv
